[rtl/mbrf_pkg.sv]
// Shared types, sizes and codes for the multichannel batch ring FIFO.
// No dependencies; imported by mbrf_ctrl, the core and the testbench.
package mbrf_pkg;

    localparam int CHANNELS    = 4;
    localparam int DEPTH       = 64;
    localparam int SAMPLE_BITS = 16;

    localparam int CH_W   = 2;
    localparam int SMP_W  = 16;
    localparam int LEN_W  = 6;
    localparam int KIND_W = 2;

    localparam int CHI_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ADDR_W  = $clog2(CHANNELS * DEPTH);
    localparam int MAX_RUN = (1 << LEN_W) - 1;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = KIND_W;

    typedef logic [CHI_W-1:0]       t_chi;
    typedef logic [PTR_W-1:0]       t_ptr;
    typedef logic [CNT_W-1:0]       t_cnt;
    typedef logic [LEN_W-1:0]       t_len;
    typedef logic [ADDR_W-1:0]      t_addr;
    typedef logic [SAMPLE_BITS-1:0] t_word;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_PULL = 1'b1
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACK    = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_EMPTY  = 2'd2
    } t_kind;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_word wdata;
        logic  re;
        t_addr raddr;
    } t_ram_req;

    typedef struct packed {
        logic            vld;
        logic            from_ram;
        t_kind           kind;
        logic [CH_W-1:0] ch;
        logic            accepted;
        logic            last;
        t_len            run_len;
    } t_res;

endpackage

[rtl/multichannel_batch_ring_fifo_core.sv]
// Multichannel batch ring FIFO: per-channel ring buffers of samples in one shared
// RAM. A push request answers with one acknowledge; a pull that finds the channel
// empty answers once; a pull that drains n samples answers with n samples and
// holds off the input until the drain is over, since the drain walks the sample
// RAM through its single read port at one sample per cycle unless the receiver
// stalls. Results sit in an output register; a new request is taken only while
// that register is empty or is emptied in the same cycle, so a stalled receiver
// stalls the input.
// Depends on mbrf_pkg, mbrf_ctrl and mbrf_ram.
module multichannel_batch_ring_fifo_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // channel[1:0], sample[17:2], batch_len[23:18]
    input  logic [mbrf_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // opcode[0], first_in_batch[1]
    input  logic [mbrf_pkg::S_TUSER_W-1:0]     i_s_tuser,
    input  logic                               i_s_tlast,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // out_channel[1:0], out_sample[17:2], accepted[18], run_length[24:19], zero[31:25]
    output logic [mbrf_pkg::M_TDATA_W-1:0]     o_m_tdata,
    // kind[1:0]
    output logic [mbrf_pkg::M_TUSER_W-1:0]     o_m_tuser,
    output logic                               o_m_tlast
);
    import mbrf_pkg::*;

    t_ram_req ram_req;
    t_res     res;
    t_word    ram_rdata;
    logic     out_free;

    logic                   r_m_tvalid;
    logic [CH_W-1:0]        r_ch;
    logic signed [SMP_W-1:0] r_sample;
    logic                   r_accepted;
    t_len                   r_run;
    t_kind                  r_kind;
    logic                   r_last;

    assign out_free = !r_m_tvalid || i_m_tready;

    mbrf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (i_s_tvalid),
        .o_rdy      (o_s_tready),
        .i_op       (i_s_tuser[0]),
        .i_ch       (i_s_tdata[1:0]),
        .i_sample   (i_s_tdata[17:2]),
        .i_blen     (i_s_tdata[23:18]),
        .i_first    (i_s_tuser[1]),
        .i_last     (i_s_tlast),
        .i_out_free (out_free),
        .o_ram      (ram_req),
        .o_res      (res)
    );

    mbrf_ram #(
        .DATA_W (SAMPLE_BITS),
        .WORDS  (CHANNELS * DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (res.vld) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.vld) begin
            r_ch       <= res.ch;
            r_sample   <= res.from_ram ? signed'(SMP_W'(ram_rdata)) : '0;
            r_accepted <= res.accepted;
            r_run      <= res.run_len;
            r_kind     <= res.kind;
            r_last     <= res.last;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = M_TDATA_W'({r_run, r_accepted, r_sample, r_ch});
    assign o_m_tuser  = r_kind;
    assign o_m_tlast  = r_last;

endmodule

[rtl/mbrf_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module mbrf_ram #(
    parameter int DATA_W = 16,
    parameter int WORDS  = 256,
    parameter int ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [WORDS];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/mbrf_ctrl.sv]
// Channel state file, push admission and drain sequencer of the batch ring FIFO.
// Depends on mbrf_pkg; drives the sample RAM requests and the result stream.
module mbrf_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    output logic                        o_rdy,
    input  logic                        i_op,
    input  logic [mbrf_pkg::CH_W-1:0]   i_ch,
    input  logic signed [mbrf_pkg::SMP_W-1:0] i_sample,
    input  logic [mbrf_pkg::LEN_W-1:0]  i_blen,
    input  logic                        i_first,
    input  logic                        i_last,
    input  logic                        i_out_free,
    output mbrf_pkg::t_ram_req          o_ram,
    output mbrf_pkg::t_res              o_res
);
    import mbrf_pkg::*;

    function automatic t_ptr ptr_add(t_ptr a, t_cnt b);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
        if (s >= (CNT_W + 1)'(DEPTH)) begin
            s = s - (CNT_W + 1)'(DEPTH);
        end
        return t_ptr'(s);
    endfunction

    function automatic t_addr ram_addr(t_chi c, t_ptr p);
        return t_addr'(int'(c) * DEPTH + int'(p));
    endfunction

    t_ptr r_tail [CHANNELS];
    t_ptr r_head [CHANNELS];
    t_cnt r_cnt  [CHANNELS];
    t_cnt r_pend [CHANNELS];
    logic r_adm  [CHANNELS];

    t_state          r_state, n_state;
    t_ptr            r_rptr;
    t_chi            r_rch;
    logic [CH_W-1:0] r_och;
    t_len            r_rem;
    t_len            r_run;
    logic            r_rd_vld;
    logic            r_rd_last;

    logic ch_ok;
    t_chi ci;
    t_ptr cur_tail, cur_head;
    t_cnt cur_cnt, cur_pend;
    logic cur_adm;
    logic p_adm, p_wr;
    t_cnt p_pend, p_pend2;
    t_len pull_n;
    logic pull_empty;
    logic acc, xfer, issue;

    assign ch_ok    = (int'(i_ch) < CHANNELS);
    assign ci       = t_chi'(i_ch);
    assign cur_tail = r_tail[ci];
    assign cur_head = r_head[ci];
    assign cur_cnt  = r_cnt[ci];
    assign cur_pend = r_pend[ci];
    assign cur_adm  = r_adm[ci];

    assign p_adm   = i_first ? (int'(t_cnt'(DEPTH) - cur_cnt) > int'(i_blen)) : cur_adm;
    assign p_pend  = i_first ? '0 : cur_pend;
    assign p_wr    = ch_ok && p_adm && (int'(cur_cnt) + int'(p_pend) < DEPTH - 1);
    assign p_pend2 = p_pend + t_cnt'(p_wr);

    assign pull_n     = (int'(cur_cnt) > MAX_RUN) ? t_len'(MAX_RUN) : t_len'(cur_cnt);
    assign pull_empty = !ch_ok || (cur_cnt == '0);

    assign acc   = i_vld && o_rdy;
    assign xfer  = r_rd_vld && i_out_free;
    assign issue = (r_state == ST_DRAIN) && (r_rem != '0) && (!r_rd_vld || xfer);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (acc && (t_op'(i_op) == OP_PULL) && !pull_empty) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if ((r_rem == '0) && (!r_rd_vld || xfer)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_rdy          = 1'b0;
        o_res          = '0;
        o_res.kind     = KIND_ACK;
        o_ram.we       = acc && (t_op'(i_op) == OP_PUSH) && p_wr;
        o_ram.waddr    = ram_addr(ci, ptr_add(cur_tail, p_pend));
        o_ram.wdata    = t_word'($unsigned(i_sample));
        o_ram.re       = issue;
        o_ram.raddr    = ram_addr(r_rch, r_rptr);
        case (r_state)
            ST_IDLE: begin
                o_rdy          = i_out_free;
                o_res.vld      = acc && ((t_op'(i_op) == OP_PUSH) || pull_empty);
                o_res.kind     = (t_op'(i_op) == OP_PUSH) ? KIND_ACK : KIND_EMPTY;
                o_res.ch       = i_ch;
                o_res.accepted = (t_op'(i_op) == OP_PUSH) && p_wr;
                o_res.last     = 1'b1;
            end
            ST_DRAIN: begin
                o_res.vld      = xfer;
                o_res.from_ram = 1'b1;
                o_res.kind     = KIND_SAMPLE;
                o_res.ch       = r_och;
                o_res.last     = r_rd_last;
                o_res.run_len  = r_run;
            end
            default: o_rdy = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_tail[c] <= '0;
                r_head[c] <= '0;
                r_cnt[c]  <= '0;
                r_pend[c] <= '0;
                r_adm[c]  <= 1'b0;
            end
        end else if (acc && ch_ok) begin
            if (t_op'(i_op) == OP_PUSH) begin
                if (i_last) begin
                    if (p_adm) begin
                        r_cnt[ci]  <= cur_cnt + p_pend2;
                        r_tail[ci] <= ptr_add(cur_tail, p_pend2);
                    end
                    r_adm[ci]  <= 1'b0;
                    r_pend[ci] <= '0;
                end else begin
                    r_adm[ci]  <= p_adm;
                    r_pend[ci] <= p_pend2;
                end
            end else if (!pull_empty) begin
                r_head[ci] <= ptr_add(cur_head, t_cnt'(pull_n));
                r_cnt[ci]  <= cur_cnt - t_cnt'(pull_n);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rem     <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
        end else begin
            r_state <= n_state;
            if (acc && (t_op'(i_op) == OP_PULL) && !pull_empty) begin
                r_rem <= pull_n;
            end else if (issue) begin
                r_rem <= r_rem - t_len'(1);
            end
            if (issue) begin
                r_rd_vld  <= 1'b1;
                r_rd_last <= (r_rem == t_len'(1));
            end else if (xfer) begin
                r_rd_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && (t_op'(i_op) == OP_PULL)) begin
            r_rptr <= cur_head;
            r_rch  <= ci;
            r_och  <= i_ch;
            r_run  <= pull_n;
        end else if (issue) begin
            r_rptr <= ptr_add(r_rptr, t_cnt'(1));
        end
    end

`ifndef SYNTHESIS
    for (genvar g = 0; g < CHANNELS; g++) begin : g_chk
        a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            int'(r_cnt[g]) + int'(r_pend[g]) <= DEPTH - 1)
            else $error("channel occupancy exceeds capacity");
    end

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> ((r_rem == '0) && !r_rd_vld))
        else $error("drain work left over in idle");

    a_last_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_vld && r_rd_last) |-> (r_rem == '0))
        else $error("last drained sample with reads outstanding");

    a_no_write_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> (!o_ram.we && !o_rdy))
        else $error("request taken during drain");
`endif

endmodule

[test/tb_multichannel_batch_ring_fifo_core.sv]
// Self-checking testbench for multichannel_batch_ring_fifo_core: batch pushes, drains,
// restarts, rejections and overflow under several idle and stall patterns.
// Depends on mbrf_pkg and the core RTL; a scoreboard class predicts every result.
`timescale 1ns / 100ps

module tb_multichannel_batch_ring_fifo_core;
    import mbrf_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT  = 4000;
    localparam int PHASE_ITEMS = 108;

    typedef struct packed {
        t_kind       kind;
        logic [1:0]  ch;
        logic [15:0] smp;
        logic        acc;
        logic        last;
        logic [5:0]  len;
    } t_answer;

    class ring_scoreboard;
        logic [15:0] ring [CHANNELS*DEPTH];
        int unsigned wr_ptr [CHANNELS];
        int unsigned rd_ptr [CHANNELS];
        int unsigned level [CHANNELS];
        int unsigned open_cnt [CHANNELS];
        bit          admitted [CHANNELS];
        t_answer     answers_due [$];
        int          errors;
        int          n_requests;
        int          n_pulls;
        int          n_results;
        int          longest_run;

        function new();
            for (int c = 0; c < CHANNELS; c++) begin
                wr_ptr[c]   = 0;
                rd_ptr[c]   = 0;
                level[c]    = 0;
                open_cnt[c] = 0;
                admitted[c] = 0;
            end
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("MISMATCH %s: got 0x%0h, expected 0x%0h (result %0d)",
                     what, got, want, n_results);
        endtask

        function void apply_request(t_op op, int unsigned ch, logic [15:0] smp,
                                    int unsigned blen, bit first, bit last);
            t_answer     a;
            int unsigned n;
            n_requests++;
            a.kind = KIND_ACK;
            a.ch   = ch[1:0];
            a.smp  = '0;
            a.acc  = 1'b0;
            a.last = 1'b1;
            a.len  = '0;
            if (op == OP_PUSH) begin
                if (first) begin
                    admitted[ch] = (DEPTH - level[ch]) > blen;
                    open_cnt[ch] = 0;
                end
                if (admitted[ch] && level[ch] + open_cnt[ch] < DEPTH - 1) begin
                    ring[ch*DEPTH + (wr_ptr[ch] + open_cnt[ch]) % DEPTH] = smp;
                    open_cnt[ch]++;
                    a.acc = 1'b1;
                end
                if (last) begin
                    if (admitted[ch]) begin
                        level[ch] += open_cnt[ch];
                        wr_ptr[ch] = (wr_ptr[ch] + open_cnt[ch]) % DEPTH;
                    end
                    admitted[ch] = 0;
                    open_cnt[ch] = 0;
                end
                answers_due.push_back(a);
            end else begin
                n_pulls++;
                if (level[ch] == 0) begin
                    a.kind = KIND_EMPTY;
                    answers_due.push_back(a);
                end else begin
                    n = (level[ch] > 63) ? 63 : level[ch];
                    if (n > longest_run) longest_run = n;
                    for (int i = 0; i < n; i++) begin
                        a.kind = KIND_SAMPLE;
                        a.smp  = ring[ch*DEPTH + (rd_ptr[ch] + i) % DEPTH];
                        a.last = (i + 1 == n);
                        a.len  = n[5:0];
                        answers_due.push_back(a);
                    end
                    rd_ptr[ch] = (rd_ptr[ch] + n) % DEPTH;
                    level[ch] -= n;
                end
            end
        endfunction

        task check_answer(logic [31:0] data, logic [1:0] user, logic last);
            t_answer want;
            n_results++;
            if (answers_due.size() == 0) begin
                report("result with nothing expected", data, 0);
                return;
            end
            want = answers_due.pop_front();
            if (user !== want.kind)
                report("kind", 32'(user), 32'(want.kind));
            if (data[1:0] !== want.ch)
                report("channel", 32'(data[1:0]), 32'(want.ch));
            if (data[17:2] !== want.smp)
                report("sample", 32'(data[17:2]), 32'(want.smp));
            if (data[18] !== want.acc)
                report("accepted", 32'(data[18]), 32'(want.acc));
            if (data[24:19] !== want.len)
                report("run length", 32'(data[24:19]), 32'(want.len));
            if (last !== want.last)
                report("last of run", 32'(last), 32'(want.last));
        endtask
    endclass

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    // channel[1:0], sample[17:2], batch_len[23:18]
    logic [S_TDATA_W-1:0] i_s_tdata  = '0;
    // opcode[0], first_in_batch[1]
    logic [S_TUSER_W-1:0] i_s_tuser  = '0;
    logic                 i_s_tlast  = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    // out_channel[1:0], out_sample[17:2], accepted[18], run_length[24:19], zero[31:25]
    logic [M_TDATA_W-1:0] o_m_tdata;
    // kind[1:0]
    logic [M_TUSER_W-1:0] o_m_tuser;
    logic                 o_m_tlast;

    ring_scoreboard sb = new();

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit rx_hold_req  = 1'b0;
    int n_sent       = 0;

    multichannel_batch_ring_fifo_core dut (.*);

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready)
                sb.check_answer(o_m_tdata, o_m_tuser, o_m_tlast);
            if (i_s_tvalid && o_s_tready)
                sb.apply_request(t_op'(i_s_tuser[0]), 32'(i_s_tdata[1:0]),
                                 i_s_tdata[17:2], 32'(i_s_tdata[23:18]),
                                 i_s_tuser[1], i_s_tlast);
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no request or result moved for %0d cycles", IDLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                i_m_tready <= 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    task automatic offer(t_op op, logic [1:0] ch, logic [15:0] smp, logic [5:0] blen,
                         logic first, logic last);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {blen, smp, ch};
        i_s_tuser  <= {first, op};
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        n_sent++;
    endtask

    task automatic pull(logic [1:0] ch);
        offer(OP_PULL, ch, 16'($urandom), 6'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic push_batch(logic [1:0] ch, int n, logic [5:0] declared,
                              bit with_first, bit with_last);
        for (int i = 0; i < n; i++)
            offer(OP_PUSH, ch, 16'($urandom), (i == 0) ? declared : 6'($urandom),
                  with_first && (i == 0), with_last && (i == n - 1));
    endtask

    // hold the input quiet until every result has drained
    task automatic settle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.answers_due.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int          goal;
        int          r;
        int          n;
        logic [1:0]  ch;
        logic [5:0]  declared;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        pull(2'd0);
        offer(OP_PUSH, 2'd0, 16'h7FFF, 6'd2, 1'b1, 1'b0);
        offer(OP_PUSH, 2'd0, 16'h8000, 6'h3F, 1'b0, 1'b1);
        pull(2'd0);
        // zero-length batch
        offer(OP_PUSH, 2'd1, 16'hFFFF, 6'd0, 1'b1, 1'b1);
        // stray sample outside any batch
        offer(OP_PUSH, 2'd2, 16'h0000, 6'd5, 1'b0, 1'b0);
        // restart an open batch
        offer(OP_PUSH, 2'd3, 16'h1234, 6'd3, 1'b1, 1'b0);
        offer(OP_PUSH, 2'd3, 16'hABCD, 6'd1, 1'b1, 1'b1);
        // pull in the middle of an open batch
        offer(OP_PUSH, 2'd1, 16'h0001, 6'd2, 1'b1, 1'b0);
        pull(2'd1);
        offer(OP_PUSH, 2'd1, 16'hFFFE, 6'd0, 1'b0, 1'b1);
        pull(2'd1);
        // rejected, then admitted at the largest declared length
        offer(OP_PUSH, 2'd3, 16'h5555, 6'd63, 1'b1, 1'b1);
        offer(OP_PUSH, 2'd2, 16'hAAAA, 6'd63, 1'b1, 1'b1);
        pull(2'd3);
        pull(2'd2);
        settle();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  rx_hold_req = 1'b1; end
                1: begin tx_idle_pct = 87; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 87; end
                default: begin tx_idle_pct = 32; rx_stall_pct = 32; end
            endcase
            goal = n_sent + PHASE_ITEMS;
            // overfill one channel past its capacity
            push_batch(2'(phase), 66, 6'd2, 1'b1, 1'b1);
            pull(2'(phase));
            while (n_sent < goal) begin
                r  = $urandom_range(0, 99);
                ch = 2'($urandom_range(0, 3));
                if (r < 50) begin
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                    : $urandom_range(1, 12);
                    declared = ($urandom_range(0, 3) != 0) ? 6'(n) : 6'($urandom);
                    push_batch(ch, n, declared, 1'b1, 1'b1);
                end else if (r < 68) begin
                    pull(ch);
                end else if (r < 76) begin
                    declared = 6'($urandom_range(0, 20));
                    push_batch(ch, declared + $urandom_range(1, 5), declared, 1'b1, 1'b1);
                end else if (r < 86) begin
                    if ($urandom_range(0, 1))
                        push_batch(ch, $urandom_range(1, 4), 6'($urandom), 1'b1, 1'b0);
                    else
                        push_batch(ch, $urandom_range(1, 4), 6'($urandom), 1'b0, 1'b1);
                end else begin
                    offer(t_op'($urandom_range(0, 1)), ch, 16'($urandom), 6'($urandom),
                          1'($urandom), 1'($urandom));
                end
            end
            settle();
        end

        repeat (20) @(posedge i_clk);

        $display("covered %0d requests (%0d pulls) and %0d results, longest drain %0d",
                 sb.n_requests, sb.n_pulls, sb.n_results, sb.longest_run);
        $display("idle patterns: none, sender, receiver, both, plus one long receiver hold");
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/mbrf_pkg.sv
rtl/mbrf_ram.sv
rtl/mbrf_ctrl.sv
rtl/multichannel_batch_ring_fifo_core.sv
test/tb_multichannel_batch_ring_fifo_core.sv
